// File: design/box_blur_3x3_rgb_defines.svh
// ---------------------------------------------------------------------------
// Box blur assertion macros
// Shared concurrent assertion forms for the box blur checker.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur check failed");

// Next-cycle implication, disabled while reset is low.
`define BBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur check failed");

`endif

// File: design/bbr_pkg.sv
// ---------------------------------------------------------------------------
// Box blur package
// Types and fixed constants shared by the box blur modules.
// ---------------------------------------------------------------------------
package bbr_pkg;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int WREG_W   = 12;
    localparam int SUM_W    = 12;
    localparam int DIV9_SHIFT = 15;
    localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;
    localparam logic [CH_W-1:0]  ALPHA_VAL = 8'hFF;
    localparam logic [WREG_W-1:0] WIDTH_RESET = 12'd640;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One column of the tap window: [0] top, [1] middle, [2] bottom.
    typedef logic [2:0][PIX_W-1:0] bbr_col_t;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pix;
        logic             first;
        logic             last;
        logic             drain;
        logic             emit_en;
    } bbr_entry_t;

    typedef enum logic {
        BK_SHIFT,
        BK_FLUSH
    } bbr_back_state_t;

endpackage

// File: design/bbr_ifs.sv
// ---------------------------------------------------------------------------
// Box blur channel interfaces
// Valid/ready channels for pixels, results and the width register.
// ---------------------------------------------------------------------------
interface bbr_in_if;
    import bbr_pkg::*;

    logic            valid;
    logic            ready;
    logic            action;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] red_in;

    modport source (output valid, output action, output blue_in, output green_in,
                    output red_in, input ready);
    modport sink (input valid, input action, input blue_in, input green_in,
                  input red_in, output ready);
endinterface

interface bbr_out_if;
    import bbr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] alpha_out;
    logic            row_end;
    logic            frame_end;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output alpha_out, output row_end, output frame_end, input ready);
    modport sink (input valid, input blue_out, input green_out, input red_out,
                  input alpha_out, input row_end, input frame_end, output ready);
endinterface

interface bbr_cfg_if;
    import bbr_pkg::*;

    logic              valid;
    logic              ready;
    logic [WREG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/bbr_ram.sv
// ---------------------------------------------------------------------------
// Box blur generic RAM
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module bbr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: design/bbr_front.sv
// ---------------------------------------------------------------------------
// Box blur front end
// Accepts pixels, tracks row position, reads and updates the line stores.
// ---------------------------------------------------------------------------
module bbr_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bbr_in_if.sink                    pixel,
    bbr_cfg_if.sink                   cfg,
    input  logic [bbr_pkg::QCNT_W-1:0] q_free,
    output logic                      push,
    output bbr_pkg::bbr_entry_t       push_entry
);
    import bbr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > WREG_W) ? CW + 1 : WREG_W;

    logic [WREG_W-1:0] width_reg;
    logic [CW-1:0]     col_reg, col_next;
    logic [1:0]        rows_reg, rows_next;
    logic              s1_valid_reg;

    logic [CW-1:0]     s1_col_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic              s1_first_reg, s1_last_reg, s1_drain_reg, s1_rs1_reg, s1_rs2_reg;
    logic              s1_fwd_reg;
    logic [PIX_W-1:0]  fwd_up_reg, fwd_mid_reg;

    logic [LW-1:0]     width_ext, eff_width;
    logic [CW-1:0]     last_col, cur_col;
    logic              is_last, accept, drop, take, fwd_hit;
    logic [PIX_W-1:0]  in_pix, rd_up, rd_mid;
    logic [2*PIX_W-1:0] ram_rdata;

    assign width_ext = LW'(width_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            eff_width = LW'(1);
        end
        else if (width_ext > LW'(MAX_WIDTH))
        begin
            eff_width = LW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
    end

    assign last_col = CW'(eff_width - LW'(1));
    assign cur_col  = (col_reg > last_col) ? last_col : col_reg;
    assign is_last  = (cur_col == last_col);

    // One slot is kept for the item already in the read stage.
    assign pixel.ready = (q_free > QCNT_W'(s1_valid_reg));
    assign cfg.ready   = 1'b1;

    assign accept  = pixel.valid && pixel.ready;
    assign drop    = pixel.action && (rows_reg == 2'd0) && (col_reg == '0);
    assign take    = accept && !drop;
    assign fwd_hit = s1_valid_reg && (s1_col_reg == cur_col);
    assign in_pix  = pixel.action ? '0 : {pixel.red_in, pixel.green_in, pixel.blue_in};

    always_comb
    begin
        col_next  = col_reg;
        rows_next = rows_reg;
        if (take)
        begin
            if (is_last)
            begin
                col_next = '0;
                if (pixel.action)
                begin
                    rows_next = 2'd0;
                end
                else if (rows_reg != 2'd2)
                begin
                    rows_next = rows_reg + 2'd1;
                end
            end
            else
            begin
                col_next = cur_col + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            col_reg      <= '0;
            rows_reg     <= 2'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                width_reg <= cfg.data;
            end
            col_reg      <= col_next;
            rows_reg     <= rows_next;
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_col_reg   <= cur_col;
            s1_pix_reg   <= in_pix;
            s1_first_reg <= (cur_col == '0);
            s1_last_reg  <= is_last;
            s1_drain_reg <= pixel.action;
            s1_rs1_reg   <= (rows_reg != 2'd0);
            s1_rs2_reg   <= (rows_reg == 2'd2);
            s1_fwd_reg   <= fwd_hit;
            fwd_up_reg   <= rd_mid;
            fwd_mid_reg  <= s1_pix_reg;
        end
    end

    // The line stores hold {upper, middle} side by side at each column.
    bbr_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({rd_mid, s1_pix_reg}),
        .re    (take),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    // Same column written by the previous item in the read cycle: forward it.
    assign rd_up  = s1_fwd_reg ? fwd_up_reg  : ram_rdata[2*PIX_W-1:PIX_W];
    assign rd_mid = s1_fwd_reg ? fwd_mid_reg : ram_rdata[PIX_W-1:0];

    assign push = s1_valid_reg;

    always_comb
    begin
        push_entry.top     = s1_rs2_reg ? rd_up : '0;
        push_entry.mid     = rd_mid;
        push_entry.pix     = s1_pix_reg;
        push_entry.first   = s1_first_reg;
        push_entry.last    = s1_last_reg;
        push_entry.drain   = s1_drain_reg;
        push_entry.emit_en = s1_rs1_reg;
    end
endmodule

// File: design/bbr_queue.sv
// ---------------------------------------------------------------------------
// Box blur queue
// Short FIFO of classified items between the front and back ends.
// ---------------------------------------------------------------------------
module bbr_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bbr_pkg::bbr_entry_t        push_entry,
    input  logic                       pop,
    output logic                       head_valid,
    output bbr_pkg::bbr_entry_t        head_entry,
    output logic [bbr_pkg::QCNT_W-1:0] free
);
    import bbr_pkg::*;

    bbr_entry_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign free       = QCNT_W'(QDEPTH) - count_reg;
endmodule

// File: design/bbr_back.sv
// ---------------------------------------------------------------------------
// Box blur back end
// Shifts the tap window, sums nine taps, divides by nine, holds the result.
// ---------------------------------------------------------------------------
module bbr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  bbr_pkg::bbr_entry_t head_entry,
    output logic                pop,
    bbr_out_if.source           result
);
    import bbr_pkg::*;

    bbr_back_state_t state_reg, state_next;
    logic            pend_drain_reg;

    bbr_col_t        win_reg [3];
    bbr_col_t        win_next [3];
    logic            w_valid_reg, w_row_end_reg, w_frame_end_reg;

    logic [SUM_W-1:0] sum_reg [3];
    logic             s_valid_reg, s_row_end_reg, s_frame_end_reg;

    logic [CH_W-1:0]  q_reg [3];
    logic             o_valid_reg, o_row_end_reg, o_frame_end_reg;

    logic             adv, s_ready, o_ready;
    logic             step, clear, emit, tok_row_end, tok_frame_end;
    bbr_col_t         new_col;
    logic [SUM_W-1:0] col_sum [3][3];
    logic [SUM_W-1:0] sum_comb [3];
    logic [2*SUM_W-1:0] prod [3];

    assign o_ready = !o_valid_reg || result.ready;
    assign s_ready = !s_valid_reg || o_ready;
    assign adv     = !w_valid_reg || s_ready;

    // Next state: a row's last item needs one more zero column shifted in.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_SHIFT:
            begin
                if (adv && head_valid && head_entry.last && head_entry.emit_en)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (adv)
                begin
                    state_next = BK_SHIFT;
                end
            end
            default:
            begin
                state_next = BK_SHIFT;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        pop           = 1'b0;
        step          = 1'b0;
        clear         = 1'b0;
        emit          = 1'b0;
        tok_row_end   = 1'b0;
        tok_frame_end = 1'b0;
        new_col       = '0;
        case (state_reg)
            BK_SHIFT:
            begin
                pop     = adv && head_valid;
                step    = pop;
                clear   = head_entry.first;
                emit    = head_entry.emit_en && !head_entry.first;
                new_col = {head_entry.pix, head_entry.mid, head_entry.top};
            end
            BK_FLUSH:
            begin
                step          = adv;
                emit          = 1'b1;
                tok_row_end   = 1'b1;
                tok_frame_end = pend_drain_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        win_next = win_reg;
        if (step)
        begin
            if (clear)
            begin
                win_next[0] = '0;
                win_next[1] = '0;
            end
            else
            begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
            end
            win_next[2] = new_col;
        end
    end

    // Column sums first, then the three columns.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                col_sum[ch][c] = SUM_W'(win_reg[c][0][ch*CH_W +: CH_W])
                               + SUM_W'(win_reg[c][1][ch*CH_W +: CH_W])
                               + SUM_W'(win_reg[c][2][ch*CH_W +: CH_W]);
            end
            sum_comb[ch] = col_sum[ch][0] + col_sum[ch][1] + col_sum[ch][2];
        end
    end

    // Divide by nine: multiply by the reciprocal and drop the low bits.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = (2*SUM_W)'(sum_reg[ch]) * (2*SUM_W)'(DIV9_MUL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_SHIFT;
            w_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                w_valid_reg <= step && emit;
            end
            if (s_ready)
            begin
                s_valid_reg <= w_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (pop)
        begin
            pend_drain_reg <= head_entry.drain;
        end
        if (adv)
        begin
            w_row_end_reg   <= tok_row_end;
            w_frame_end_reg <= tok_frame_end;
        end
        if (s_ready)
        begin
            sum_reg         <= sum_comb;
            s_row_end_reg   <= w_row_end_reg;
            s_frame_end_reg <= w_frame_end_reg;
        end
        if (o_ready)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                q_reg[ch] <= prod[ch][DIV9_SHIFT +: CH_W];
            end
            o_row_end_reg   <= s_row_end_reg;
            o_frame_end_reg <= s_frame_end_reg;
        end
    end

    assign result.valid     = o_valid_reg;
    assign result.blue_out  = q_reg[0];
    assign result.green_out = q_reg[1];
    assign result.red_out   = q_reg[2];
    assign result.alpha_out = ALPHA_VAL;
    assign result.row_end   = o_row_end_reg;
    assign result.frame_end = o_frame_end_reg;
endmodule

// File: design/box_blur_3x3_rgb.sv
// Throughput: one pixel word per clock while the queue has room; the second result at a row end
//   costs the back end an extra flush step, absorbed by the 4-entry queue.
// Reset: rst_n (async, active low) clears position, row count, queue and valid flags and
//   sets the width register to 640; line stores are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// Box blur 3x3 RGB
// Streaming 3x3 mean filter over BGRA pixels with two line stores.
// ---------------------------------------------------------------------------
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic      clk,
    input  logic      rst_n,
    bbr_in_if.sink    pixel,
    bbr_out_if.source result,
    bbr_cfg_if.sink   cfg
);
    import bbr_pkg::*;

    // Front end to queue: one classified word per accepted, non-dropped pixel,
    // carrying the taps read from the line stores.
    logic              push;
    bbr_entry_t        push_entry;

    // Queue to back end.
    logic              pop;
    logic              head_valid;
    bbr_entry_t        head_entry;
    logic [QCNT_W-1:0] q_free;

    // Front: hold position in the row, read the column from both line stores,
    // forward when the item in the read stage writes the same column, and drop a
    // drain word that arrives with no pending row.
    bbr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .q_free     (q_free),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: let the front keep taking pixels while the back end spends an
    // extra flush step on a row end or waits on a stalled result.
    bbr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .free       (q_free)
    );

    // Back: advance the window, sum, divide by nine and hold the result word
    // in an output register so the sink may stall freely.
    bbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .result     (result)
    );
endmodule

// File: design/bbr_checker.sv
// ---------------------------------------------------------------------------
// Box blur checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "box_blur_3x3_rgb_defines.svh"

module bbr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] blue_out,
    input logic [7:0] green_out,
    input logic [7:0] red_out,
    input logic [7:0] alpha_out,
    input logic       row_end,
    input logic       frame_end
);
    `BBR_ASSERT_NEXT(a_valid_hold, clk, rst_n, res_valid && !res_ready, res_valid)
    `BBR_ASSERT_NEXT(a_data_hold, clk, rst_n, res_valid && !res_ready, $stable({blue_out, green_out, red_out, row_end, frame_end}))
    `BBR_ASSERT_NOW(a_alpha_opaque, clk, rst_n, res_valid, alpha_out == 8'hFF)
    `BBR_ASSERT_NOW(a_frame_ends_row, clk, rst_n, res_valid && frame_end, row_end)
endmodule

bind box_blur_3x3_rgb bbr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .blue_out  (result.blue_out),
    .green_out (result.green_out),
    .red_out   (result.red_out),
    .alpha_out (result.alpha_out),
    .row_end   (result.row_end),
    .frame_end (result.frame_end)
);
